[rtl/frcd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the feature report command decoder.
// No dependencies; used by frcd_decode and feature_report_command_decoder.
package frcd_pkg;

    localparam int unsigned InTdataW  = 56;
    localparam int unsigned OutTdataW = 16;

    localparam logic [7:0] MinLength     = 8'd4;
    localparam logic [7:0] LongLength    = 8'd5;
    localparam logic [7:0] HeaderByte    = 8'h5a;
    localparam logic [7:0] GroupControl  = 8'hd0;
    localparam logic [7:0] GroupLight    = 8'hba;
    localparam logic [7:0] SelFnRow      = 8'h4e;
    localparam logic [7:0] SelChannel    = 8'h7c;
    localparam logic [7:0] SelAux        = 8'h85;
    localparam logic [7:0] SelTimed      = 8'h8f;
    localparam logic [7:0] LightSig0     = 8'hc5;
    localparam logic [7:0] LightSig1     = 8'hc4;
    localparam logic [7:0] AuxValue      = 8'hff;
    localparam logic [7:0] AuxExtra      = 8'h80;
    localparam logic [7:0] ValZero       = 8'h00;
    localparam logic [7:0] ValOne        = 8'h01;
    localparam logic [7:0] LightOff      = 8'h00;
    localparam logic [7:0] LightLow      = 8'h43;
    localparam logic [7:0] LightMid      = 8'h87;
    localparam logic [7:0] LightHigh     = 8'hcc;

    typedef enum logic [1:0] {
        ST_REJECTED = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_QUEUED   = 2'd2
    } t_status;

    typedef enum logic {
        CMD_REPORT  = 1'b0,
        CMD_SERVICE = 1'b1
    } t_command;

    // Backlight level codes
    localparam logic [7:0] LvlLow  = 8'd1;
    localparam logic [7:0] LvlMid  = 8'd2;
    localparam logic [7:0] LvlHigh = 8'd3;

    typedef struct packed {
        t_command   command;
        logic [7:0] report_length;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic       service_busy;
        logic       service_enabled;
    } t_item;

    // Only the bits that can ever change are held; the rest stay zero
    typedef struct packed {
        logic       fn_row;
        logic       req_action;
        logic       req_function;
        logic       channel;
        logic       aux_enable;
        logic       timed_armed;
        logic [7:0] backlight;
    } t_state;

    typedef struct packed {
        t_status    status;
        logic       serviced;
        logic       function_keys_primary;
        logic       channel_level;
        logic       aux_enable;
        logic       timed_armed;
        logic [7:0] backlight_value;
    } t_result;

    function automatic logic [7:0] light_level(input logic [7:0] code);
        logic [7:0] val;
        case (code)
            LvlLow:  val = LightLow;
            LvlMid:  val = LightMid;
            LvlHigh: val = LightHigh;
            default: val = LightOff;
        endcase
        return val;
    endfunction

endpackage

[rtl/feature_report_command_decoder.sv]
`timescale 1ns / 1ps
// Top level: input register, state registers and result register around frcd_decode.
// Depends on frcd_pkg and frcd_decode.

// Feature report command decoder. Each input transaction is one command: a
// feature report (tuser 0) or a service request for a queued Fn-row switch
// (tuser 1). Every command yields exactly one result transaction carrying the
// outcome and the current row, channel, auxiliary, timed and backlight state.
// A command is captured in an input register and decoded combinationally into an
// output register, from which its result is offered on the master side. One
// command is taken per cycle while the output is drained. Only output
// back-pressure slows the input: with the output stalled the block holds two
// commands, one in each register, before it drops tready.
// The controller state is updated as a command moves from the input to the
// output register, so each command sees the effect of all earlier ones.
module feature_report_command_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] report_length, [15:8] byte_zero, [23:16] byte_one, [31:24] byte_two,
    // [39:32] byte_three, [47:40] byte_four, [48] service_busy,
    // [49] service_enabled, [55:50] zero
    input  logic [frcd_pkg::InTdataW-1:0]   i_s_tdata,
    // [0] command
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [2] serviced, [3] function_keys_primary, [4] channel_level,
    // [5] aux_enable, [6] timed_armed, [14:7] backlight_value, [15] zero
    output logic [frcd_pkg::OutTdataW-1:0]  o_m_tdata
);

    frcd_pkg::t_item   r_in;
    frcd_pkg::t_item   n_in;
    logic              r_in_valid;
    logic              n_in_valid;
    frcd_pkg::t_state  r_state;
    frcd_pkg::t_state  n_state;
    frcd_pkg::t_result r_out;
    frcd_pkg::t_result n_out;
    logic              r_out_valid;
    logic              n_out_valid;

    frcd_pkg::t_state  dec_state;
    frcd_pkg::t_result dec_result;
    logic              advance;
    logic              s_take;

    frcd_decode u_decode (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (dec_state),
        .o_result (dec_result)
    );

    // Move a command on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_take     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_in                 = r_in;
        n_in_valid           = r_in_valid;
        n_state              = r_state;
        n_out                = r_out;
        n_out_valid          = r_out_valid;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_state     = dec_state;
            n_out       = dec_result;
            n_out_valid = 1'b1;
            n_in_valid  = 1'b0;
        end
        if (s_take) begin
            n_in.command         = frcd_pkg::t_command'(i_s_tuser);
            n_in.report_length   = i_s_tdata[7:0];
            n_in.byte_zero       = i_s_tdata[15:8];
            n_in.byte_one        = i_s_tdata[23:16];
            n_in.byte_two        = i_s_tdata[31:24];
            n_in.byte_three      = i_s_tdata[39:32];
            n_in.byte_four       = i_s_tdata[47:40];
            n_in.service_busy    = i_s_tdata[48];
            n_in.service_enabled = i_s_tdata[49];
            n_in_valid           = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.backlight_value, r_out.timed_armed, r_out.aux_enable,
                         r_out.channel_level, r_out.function_keys_primary, r_out.serviced,
                         r_out.status};

    // A service transaction never reports a report outcome
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.serviced |-> r_out.status == frcd_pkg::ST_REJECTED)
        else $error("serviced result with non-rejected status");

    // Controller state moves only with a decoded command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> r_state == $past(r_state))
        else $error("state changed without a command");

    // Service commands touch only the Fn-row bits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.command == frcd_pkg::CMD_SERVICE |=>
            r_state.channel == $past(r_state.channel) &&
            r_state.backlight == $past(r_state.backlight) &&
            r_state.aux_enable == $past(r_state.aux_enable) &&
            r_state.timed_armed == $past(r_state.timed_armed))
        else $error("service command altered report state");

endmodule

[rtl/frcd_decode.sv]
`timescale 1ns / 1ps
// Command decode: next state and result for one registered command.
// Depends on frcd_pkg.
module frcd_decode (
    input  frcd_pkg::t_item   i_item,
    input  frcd_pkg::t_state  i_state,
    output frcd_pkg::t_state  o_state,
    output frcd_pkg::t_result o_result
);

    frcd_pkg::t_state  nxt;
    frcd_pkg::t_status status;
    logic              serviced;
    logic              has_five;

    always_comb begin
        nxt      = i_state;
        status   = frcd_pkg::ST_REJECTED;
        serviced = 1'b0;
        has_five = (i_item.report_length >= frcd_pkg::LongLength);

        if (i_item.command == frcd_pkg::CMD_SERVICE) begin
            // Action-keys request wins; a function-keys request stays queued
            if (!i_item.service_busy && i_item.service_enabled) begin
                if (i_state.req_action) begin
                    nxt.req_action = 1'b0;
                    nxt.fn_row     = 1'b0;
                    serviced       = 1'b1;
                end else if (i_state.req_function) begin
                    nxt.req_function = 1'b0;
                    nxt.fn_row       = 1'b1;
                    serviced         = 1'b1;
                end
            end
        end else if (i_item.report_length >= frcd_pkg::MinLength &&
                     i_item.byte_zero == frcd_pkg::HeaderByte) begin
            if (i_item.byte_one == frcd_pkg::GroupControl) begin
                case (i_item.byte_two)
                    frcd_pkg::SelFnRow: begin
                        if (i_item.byte_three == frcd_pkg::ValZero) begin
                            nxt.req_action = 1'b1;
                            status         = frcd_pkg::ST_QUEUED;
                        end else if (i_item.byte_three == frcd_pkg::ValOne) begin
                            nxt.req_function = 1'b1;
                            status           = frcd_pkg::ST_QUEUED;
                        end
                    end
                    frcd_pkg::SelChannel: begin
                        if (i_item.byte_three inside {frcd_pkg::ValZero, frcd_pkg::ValOne}) begin
                            nxt.channel = ~i_item.byte_three[0];
                            status      = frcd_pkg::ST_ACCEPTED;
                        end
                    end
                    frcd_pkg::SelAux: begin
                        if (has_five && i_item.byte_three == frcd_pkg::AuxValue &&
                            i_item.byte_four == frcd_pkg::AuxExtra) begin
                            nxt.aux_enable = 1'b1;
                            status         = frcd_pkg::ST_ACCEPTED;
                        end
                    end
                    frcd_pkg::SelTimed: begin
                        // Value one arms the timed bit; any other value leaves it and is rejected
                        if (i_item.byte_three == frcd_pkg::ValOne) begin
                            nxt.timed_armed = 1'b1;
                            status          = frcd_pkg::ST_ACCEPTED;
                        end
                    end
                    default: begin
                        status = frcd_pkg::ST_REJECTED;
                    end
                endcase
            end else if (i_item.byte_one == frcd_pkg::GroupLight && has_five &&
                         i_item.byte_two == frcd_pkg::LightSig0 &&
                         i_item.byte_three == frcd_pkg::LightSig1) begin
                nxt.backlight = frcd_pkg::light_level(i_item.byte_four);
                status        = frcd_pkg::ST_ACCEPTED;
            end
        end
    end

    assign o_state = nxt;

    assign o_result.status                = status;
    assign o_result.serviced              = serviced;
    assign o_result.function_keys_primary = nxt.fn_row;
    assign o_result.channel_level         = nxt.channel;
    assign o_result.aux_enable            = nxt.aux_enable;
    assign o_result.timed_armed           = nxt.timed_armed;
    assign o_result.backlight_value       = nxt.backlight;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for feature_report_command_decoder: directed and random
// commands on the input stream, each result checked against an in-bench decoder model.
// Depends on frcd_pkg and the RTL of feature_report_command_decoder.
module testbench;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned DrainCycles = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;

    // Controller state as the decoder should hold it; timed mode and counter
    // only ever go to zero and never show on the output
    logic [3:0]  fn_flags = '0;
    logic        chan_bit = 1'b0;
    logic [7:0]  aux_byte = '0;
    logic [7:0]  timed_flags = '0;
    logic [7:0]  light_byte = '0;

    frcd_pkg::t_result pending_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int          hold_off_cycles = 0;

    feature_report_command_decoder u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Decode one command against the held state and return what it should report
    function automatic frcd_pkg::t_result decode_command(input frcd_pkg::t_item it);
        frcd_pkg::t_result r;
        frcd_pkg::t_status st;
        logic              hit;
        st = frcd_pkg::ST_REJECTED;
        hit = 1'b0;
        if (it.command == frcd_pkg::CMD_SERVICE) begin
            if (!it.service_busy && it.service_enabled) begin
                if (fn_flags[2]) begin
                    // action keys win; a function-keys request stays queued
                    fn_flags = fn_flags & 4'b1000;
                    hit = 1'b1;
                end else if (fn_flags[3]) begin
                    fn_flags = (fn_flags & 4'b0110) | 4'b0010;
                    hit = 1'b1;
                end else begin
                    fn_flags[0] = 1'b0;
                end
            end
        end else if (it.report_length >= frcd_pkg::MinLength &&
                     it.byte_zero == frcd_pkg::HeaderByte) begin
            if (it.byte_one == frcd_pkg::GroupControl) begin
                case (it.byte_two)
                    frcd_pkg::SelFnRow: begin
                        if (it.byte_three == frcd_pkg::ValZero) begin
                            fn_flags[2] = 1'b1;
                            st = frcd_pkg::ST_QUEUED;
                        end else if (it.byte_three == frcd_pkg::ValOne) begin
                            fn_flags[3] = 1'b1;
                            st = frcd_pkg::ST_QUEUED;
                        end
                    end
                    frcd_pkg::SelChannel: begin
                        if (it.byte_three <= frcd_pkg::ValOne) begin
                            chan_bit = (it.byte_three == frcd_pkg::ValZero);
                            st = frcd_pkg::ST_ACCEPTED;
                        end
                    end
                    frcd_pkg::SelAux: begin
                        if (it.report_length >= frcd_pkg::LongLength
                            && it.byte_three == frcd_pkg::AuxValue
                            && it.byte_four == frcd_pkg::AuxExtra) begin
                            aux_byte[7] = 1'b1;
                            st = frcd_pkg::ST_ACCEPTED;
                        end
                    end
                    frcd_pkg::SelTimed: begin
                        if (it.byte_three == frcd_pkg::ValOne) begin
                            timed_flags[7] = 1'b1;
                            timed_flags[6] = 1'b0;
                            st = frcd_pkg::ST_ACCEPTED;
                        end
                    end
                    default: ;
                endcase
            end else if (it.byte_one == frcd_pkg::GroupLight
                         && it.report_length >= frcd_pkg::LongLength
                         && it.byte_two == frcd_pkg::LightSig0
                         && it.byte_three == frcd_pkg::LightSig1) begin
                case (it.byte_four)
                    frcd_pkg::LvlLow:  light_byte = frcd_pkg::LightLow;
                    frcd_pkg::LvlMid:  light_byte = frcd_pkg::LightMid;
                    frcd_pkg::LvlHigh: light_byte = frcd_pkg::LightHigh;
                    default:           light_byte = frcd_pkg::LightOff;
                endcase
                st = frcd_pkg::ST_ACCEPTED;
            end
        end
        r.status = st;
        r.serviced = hit;
        r.function_keys_primary = fn_flags[1];
        r.channel_level = chan_bit;
        r.aux_enable = aux_byte[7];
        r.timed_armed = timed_flags[7];
        r.backlight_value = light_byte;
        return r;
    endfunction

    function automatic frcd_pkg::t_item report_item(input logic [7:0] len,
                                                    input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3,
                                                    input logic [7:0] b4);
        frcd_pkg::t_item it;
        it.command = frcd_pkg::CMD_REPORT;
        it.report_length = len;
        it.byte_zero = b0;
        it.byte_one = b1;
        it.byte_two = b2;
        it.byte_three = b3;
        it.byte_four = b4;
        // gate bits mean nothing to a report; toggle them anyway
        it.service_busy = 1'($urandom_range(0, 1));
        it.service_enabled = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic frcd_pkg::t_item service_item(input logic busy, input logic enabled);
        frcd_pkg::t_item it;
        it = report_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
        it.command = frcd_pkg::CMD_SERVICE;
        it.service_busy = busy;
        it.service_enabled = enabled;
        return it;
    endfunction

    // Mostly the wanted byte, now and then a random one
    function automatic logic [7:0] mostly(input logic [7:0] want, input int unsigned odds);
        return ($urandom_range(1, odds) == 1) ? 8'($urandom) : want;
    endfunction

    task automatic send_item(input frcd_pkg::t_item it);
        int gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {6'b0, it.service_enabled, it.service_busy, it.byte_four,
                     it.byte_three, it.byte_two, it.byte_one, it.byte_zero,
                     it.report_length};
        do @(posedge clk); while (!o_s_tready);
        pending_results.push_back(decode_command(it));
    endtask

    // Receiver: random back-pressure, plus a long hold when asked for
    initial begin : result_sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            gap = recv_idle ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!o_m_tvalid);
        end
    end

    always @(posedge clk) begin
        frcd_pkg::t_result want;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", 16'(o_m_tdata[1:0]), 16'(want.status));
                if (o_m_tdata[2] !== want.serviced)
                    report_mismatch("serviced", 16'(o_m_tdata[2]), 16'(want.serviced));
                if (o_m_tdata[3] !== want.function_keys_primary)
                    report_mismatch("function_keys_primary", 16'(o_m_tdata[3]),
                                    16'(want.function_keys_primary));
                if (o_m_tdata[4] !== want.channel_level)
                    report_mismatch("channel_level", 16'(o_m_tdata[4]),
                                    16'(want.channel_level));
                if (o_m_tdata[5] !== want.aux_enable)
                    report_mismatch("aux_enable", 16'(o_m_tdata[5]), 16'(want.aux_enable));
                if (o_m_tdata[6] !== want.timed_armed)
                    report_mismatch("timed_armed", 16'(o_m_tdata[6]), 16'(want.timed_armed));
                if (o_m_tdata[14:7] !== want.backlight_value)
                    report_mismatch("backlight_value", 16'(o_m_tdata[14:7]),
                                    16'(want.backlight_value));
            end
        end
    end

    task automatic test_rejects();
        send_item(report_item(8'd3, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelChannel, frcd_pkg::ValZero, 8'h00));
        send_item(report_item(8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(report_item(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(report_item(8'd4, 8'h5b, frcd_pkg::GroupControl, frcd_pkg::SelChannel,
                              frcd_pkg::ValZero, 8'h00));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, 8'h11, frcd_pkg::SelChannel,
                              frcd_pkg::ValZero, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl, 8'h4d,
                              frcd_pkg::ValZero, 8'h00));
    endtask

    task automatic test_fn_row();
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelFnRow, frcd_pkg::ValOne, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelFnRow, frcd_pkg::ValZero, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelFnRow, 8'd2, 8'h00));
        send_item(service_item(1'b1, 1'b1));
        send_item(service_item(1'b0, 1'b0));
        // both queued: action keys first, then function keys
        send_item(service_item(1'b0, 1'b1));
        send_item(service_item(1'b0, 1'b1));
        send_item(service_item(1'b0, 1'b1));
    endtask

    task automatic test_control();
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelChannel, frcd_pkg::ValZero, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelChannel, frcd_pkg::ValOne, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelChannel, 8'd2, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelAux, frcd_pkg::AuxValue, frcd_pkg::AuxExtra));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelAux, frcd_pkg::AuxValue, 8'h81));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelAux, frcd_pkg::AuxValue, frcd_pkg::AuxExtra));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelTimed, frcd_pkg::ValZero, 8'h00));
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupControl,
                              frcd_pkg::SelTimed, frcd_pkg::ValOne, 8'h00));
    endtask

    task automatic test_backlight();
        send_item(report_item(8'd4, frcd_pkg::HeaderByte, frcd_pkg::GroupLight,
                              frcd_pkg::LightSig0, frcd_pkg::LightSig1, frcd_pkg::LvlHigh));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupLight,
                              frcd_pkg::LightSig0, frcd_pkg::LightSig1, frcd_pkg::LvlHigh));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupLight,
                              frcd_pkg::LightSig0, frcd_pkg::LightSig1, frcd_pkg::LvlMid));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupLight,
                              frcd_pkg::LightSig0, frcd_pkg::LightSig1, frcd_pkg::LvlLow));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupLight,
                              frcd_pkg::LightSig0, frcd_pkg::LightSig1, 8'hff));
        send_item(report_item(8'd5, frcd_pkg::HeaderByte, frcd_pkg::GroupLight,
                              frcd_pkg::LightSig0, 8'hc3, frcd_pkg::LvlHigh));
    endtask

    task automatic test_random(input int unsigned count, input bit idling);
        int unsigned kind;
        logic [7:0]  len;
        logic [7:0]  hdr;
        send_idle = idling;
        recv_idle = idling;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(4, 5));
            hdr = mostly(frcd_pkg::HeaderByte, 16);
            case (kind)
                0, 1: send_item(service_item($urandom_range(0, 3) == 0,
                                             $urandom_range(0, 3) != 0));
                2: send_item(report_item(len, hdr, mostly(frcd_pkg::GroupControl, 16),
                                         frcd_pkg::SelFnRow,
                                         mostly(8'($urandom_range(0, 1)), 6), 8'($urandom)));
                3: send_item(report_item(len, hdr, mostly(frcd_pkg::GroupControl, 16),
                                         frcd_pkg::SelChannel,
                                         mostly(8'($urandom_range(0, 1)), 6), 8'($urandom)));
                4: send_item(report_item(len, hdr, mostly(frcd_pkg::GroupControl, 16),
                                         frcd_pkg::SelAux, mostly(frcd_pkg::AuxValue, 4),
                                         mostly(frcd_pkg::AuxExtra, 4)));
                5: send_item(report_item(len, hdr, mostly(frcd_pkg::GroupControl, 16),
                                         frcd_pkg::SelTimed, mostly(frcd_pkg::ValOne, 3),
                                         8'($urandom)));
                6: send_item(report_item(len, hdr, mostly(frcd_pkg::GroupLight, 16),
                                         mostly(frcd_pkg::LightSig0, 8),
                                         mostly(frcd_pkg::LightSig1, 8),
                                         mostly(8'($urandom_range(0, 3)), 5)));
                7: send_item(report_item(len, hdr, frcd_pkg::GroupControl, 8'($urandom),
                                         8'($urandom), 8'($urandom)));
                default: send_item(report_item(8'($urandom),
                                               ($urandom_range(0, 1) == 1)
                                                   ? frcd_pkg::HeaderByte : 8'($urandom),
                                               8'($urandom), 8'($urandom), 8'($urandom),
                                               8'($urandom)));
            endcase
        end
    endtask

    // Hold the output off for a long stretch while commands keep coming back to back
    task automatic test_backpressure();
        send_idle = 1'b0;
        recv_idle = 1'b1;
        hold_off_cycles = 250;
        test_random(30, 1'b0);
        send_idle = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_rejects();
        test_fn_row();
        test_control();
        test_backlight();
        test_random(450, 1'b1);
        test_random(300, 1'b0);
        test_backpressure();
        test_random(450, 1'b1);
        test_random(400, 1'b1);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/frcd_pkg.sv
rtl/frcd_decode.sv
rtl/feature_report_command_decoder.sv
dv/testbench.sv
